>>> hdl/dtsg_pkg.sv
// Package of types, constants and helpers for the DCC track signal generator.
`default_nettype none
package dtsg_pkg;

    localparam int MAX_PACKET_BYTES = 8;
    localparam int IDX_W = $clog2(MAX_PACKET_BYTES);
    localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1);

    localparam logic [15:0] SHORT_HALF_RESET = 16'd116;
    localparam logic [15:0] LONG_HALF_RESET = 16'd200;
    localparam logic [7:0] PREAMBLE_RESET = 8'd16;
    localparam logic [7:0] MASK_MSB = 8'h80;
    localparam logic [LEN_W-1:0] RESET_PKT_LEN = LEN_W'(3);

    localparam logic [1:0] CFG_SHORT_HALF = 2'd0;
    localparam logic [1:0] CFG_LONG_HALF = 2'd1;
    localparam logic [1:0] CFG_PREAMBLE = 2'd2;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    typedef struct packed {
        logic [3:0] packet_length;
        logic [2:0] byte_index;
        logic [7:0] byte_value;
        logic       send_packet;
        logic       func;
    } t_item;

    typedef struct packed {
        logic [15:0] short_half_period;
        logic [15:0] long_half_period;
        logic [7:0]  preamble_bits;
    } t_cfg;

    typedef struct packed {
        logic        packet_taken;
        logic [15:0] half_period;
        logic        drive_phase;
    } t_result;

    function automatic logic [LEN_W-1:0] clamp_length(input logic [3:0] n);
        logic [LEN_W-1:0] r;
        if (n == 4'd0) begin
            r = LEN_W'(1);
        end else if (int'(n) > MAX_PACKET_BYTES) begin
            r = LEN_W'(MAX_PACKET_BYTES);
        end else begin
            r = LEN_W'(n);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/dcc_track_signal_generator.sv
// Top level of the DCC track signal generator: stream ports, registers, pipeline.
//
// Input stream words carry either a timer tick (tuser = 0) or a pending packet
// byte load (tuser = 1). Each tick yields one output word with the bridge
// phase and the timer count of the next half period; a load yields nothing.
// Configuration registers (short half, long half, preamble length) are
// written through a plain write port; write them only while the block is
// idle, which the block itself does not enforce. An accepted word enters
// an input register and is processed from there straight into the output
// register. One word is accepted every cycle, unless a tick waits on a
// stalled receiver; the single pass of sequencer logic lies between them.
// When the receiver stalls, the output word holds and the input register
// holds one more word; loads still pass through while a tick result waits.
// Synchronous reset empties both registers, restores the register defaults
// and starts a preamble with the three-zero-byte reset packet pending.
`default_nettype none
module dcc_track_signal_generator
    import dtsg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [0] send_packet, [8:1] byte_value, [11:9] byte_index, [15:12] packet_length
    input  wire logic [15:0] i_s_axis_tdata,
    // [0] func
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [0] drive_phase, [16:1] half_period, [17] packet_taken, [23:18] zero
    output logic [23:0]      o_m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_proc;
    logic    w_in_fire;

    assign w_proc = r_in_valid && (r_in.func == FUNC_LOAD || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_proc;
    assign w_in_fire = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_half_period <= SHORT_HALF_RESET;
            r_cfg.long_half_period <= LONG_HALF_RESET;
            r_cfg.preamble_bits <= PREAMBLE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SHORT_HALF: r_cfg.short_half_period <= i_cfg_wdata;
                CFG_LONG_HALF:  r_cfg.long_half_period <= i_cfg_wdata;
                CFG_PREAMBLE:   r_cfg.preamble_bits <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in.func <= i_s_axis_tuser;
            r_in.send_packet <= i_s_axis_tdata[0];
            r_in.byte_value <= i_s_axis_tdata[8:1];
            r_in.byte_index <= i_s_axis_tdata[11:9];
            r_in.packet_length <= i_s_axis_tdata[15:12];
        end
    end

    dtsg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_proc),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in.func == FUNC_TICK) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in.func == FUNC_TICK) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = {6'd0, r_out.packet_taken, r_out.half_period, r_out.drive_phase};

    a_tick_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && r_in.func == FUNC_TICK |=> r_out_valid)
        else $error("tick processed without an output word");

    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_proc |=> r_in_valid && $stable(r_in))
        else $error("stalled input word lost");

    a_second_half_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> !o_m_axis_tdata[17])
        else $error("packet taken on a second half");

endmodule
`default_nettype wire

>>> hdl/dtsg_core.sv
// Bit sequencer and packet stores of the DCC track signal generator.
`default_nettype none
module dtsg_core
    import dtsg_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    localparam logic [1:0] PH_PREAMBLE = 2'd0;
    localparam logic [1:0] PH_SEPARATOR = 2'd1;
    localparam logic [1:0] PH_BYTE = 2'd2;

    logic             r_second_half, n_second_half;
    logic [1:0]       r_phase, n_phase;
    logic [7:0]       r_preamble_left, n_preamble_left;
    logic [7:0]       r_shift_byte, n_shift_byte;
    logic [7:0]       r_bit_mask, n_bit_mask;
    logic [LEN_W-1:0] r_active_index, n_active_index;
    logic [15:0]      r_held_period, n_held_period;
    logic [LEN_W-1:0] r_active_length, n_active_length;
    logic [LEN_W-1:0] r_pending_length, n_pending_length;
    logic             r_use_zero, n_use_zero;
    logic             w_take;

    logic [7:0] r_active [MAX_PACKET_BYTES];
    logic [7:0] r_pending [MAX_PACKET_BYTES];

    logic [IDX_W-1:0] w_load_idx;
    logic             w_load_ok;
    logic [7:0]       w_active_byte;
    logic [LEN_W-1:0] w_index_inc;
    logic [7:0]       w_mask_shr;

    assign w_load_idx = IDX_W'(i_item.byte_index);
    assign w_load_ok = int'(i_item.byte_index) < MAX_PACKET_BYTES;
    assign w_index_inc = r_active_index + LEN_W'(1);
    assign w_mask_shr = r_bit_mask >> 1;
    assign w_active_byte = (r_use_zero || int'(r_active_index) >= MAX_PACKET_BYTES) ? 8'h00
                         : r_active[r_active_index[IDX_W-1:0]];

    always_comb begin
        n_second_half = r_second_half;
        n_phase = r_phase;
        n_preamble_left = r_preamble_left;
        n_shift_byte = r_shift_byte;
        n_bit_mask = r_bit_mask;
        n_active_index = r_active_index;
        n_held_period = r_held_period;
        n_active_length = r_active_length;
        n_pending_length = r_pending_length;
        n_use_zero = r_use_zero;
        w_take = 1'b0;
        o_result.drive_phase = 1'b0;
        o_result.packet_taken = 1'b0;
        o_result.half_period = r_held_period;
        if (i_item.func == FUNC_LOAD) begin
            n_pending_length = clamp_length(i_item.packet_length);
        end else if (r_second_half) begin
            n_second_half = 1'b0;
            o_result.drive_phase = 1'b1;
        end else begin
            n_second_half = 1'b1;
            unique case (r_phase)
                PH_SEPARATOR: begin
                    n_held_period = i_cfg.long_half_period;
                    n_phase = PH_BYTE;
                    n_bit_mask = MASK_MSB;
                    n_shift_byte = w_active_byte;
                end
                PH_BYTE: begin
                    n_held_period = ((r_shift_byte & r_bit_mask) != 8'h00)
                                  ? i_cfg.short_half_period : i_cfg.long_half_period;
                    n_bit_mask = w_mask_shr;
                    if (w_mask_shr == 8'h00) begin
                        n_active_index = w_index_inc;
                        if (w_index_inc >= r_active_length) begin
                            n_phase = PH_PREAMBLE;
                            n_preamble_left = i_cfg.preamble_bits;
                        end else begin
                            n_phase = PH_SEPARATOR;
                        end
                    end
                end
                default: begin
                    n_held_period = i_cfg.short_half_period;
                    n_preamble_left = r_preamble_left - 8'd1;
                    if (n_preamble_left == 8'd0) begin
                        n_phase = PH_SEPARATOR;
                        n_active_index = '0;
                        if (i_item.send_packet) begin
                            w_take = 1'b1;
                            n_active_length = r_pending_length;
                            n_use_zero = 1'b0;
                        end else begin
                            n_active_length = RESET_PKT_LEN;
                            n_use_zero = 1'b1;
                        end
                    end
                end
            endcase
            o_result.half_period = n_held_period;
            o_result.packet_taken = w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second_half <= 1'b0;
            r_phase <= PH_PREAMBLE;
            r_preamble_left <= PREAMBLE_RESET;
            r_shift_byte <= 8'h00;
            r_bit_mask <= MASK_MSB;
            r_active_index <= '0;
            r_held_period <= SHORT_HALF_RESET;
            r_active_length <= RESET_PKT_LEN;
            r_pending_length <= RESET_PKT_LEN;
            r_use_zero <= 1'b1;
        end else if (i_step) begin
            r_second_half <= n_second_half;
            r_phase <= n_phase;
            r_preamble_left <= n_preamble_left;
            r_shift_byte <= n_shift_byte;
            r_bit_mask <= n_bit_mask;
            r_active_index <= n_active_index;
            r_held_period <= n_held_period;
            r_active_length <= n_active_length;
            r_pending_length <= n_pending_length;
            r_use_zero <= n_use_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_item.func == FUNC_LOAD && w_load_ok) begin
            r_pending[w_load_idx] <= i_item.byte_value;
        end
        if (i_step && w_take) begin
            r_active <= r_pending;
        end
    end

endmodule
`default_nettype wire
